FILE: design/nss_pkg.sv
// nss_pkg: shared constants, types and helpers of the nmea sentence splitter
// used by nss_ctrl, nss_datapath and the top level nmea_sentence_splitter
package nss_pkg;

    localparam int SENTENCE_BYTES = 64;
    localparam int ADDR_W         = $clog2(SENTENCE_BYTES);
    localparam int FILL_W         = $clog2(SENTENCE_BYTES + 1);
    localparam int HEADER_LEN     = 6;

    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_HEX_A  = 8'd55;

    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_GGA     = 2'd1;
    localparam logic [1:0] KIND_RMC     = 2'd2;

    localparam logic CFG_GGA_XOR = 1'b0;
    localparam logic CFG_RMC_XOR = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;        // '$' while hunting: open a new sentence
        logic store;        // store one sentence byte
        logic load_status;  // put the invalid status beat in the output register
        logic play_init;    // rewind the playback pointer
        logic rd_issue;     // read the store at the playback pointer
        logic load_byte;    // put the read byte in the output register
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_dollar;
        logic is_cr;
        logic sum_ok;
        logic out_free;
        logic play_last;
    } t_dp_sts;

    // ascii hex character to digit, no range check
    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        if (d <= 8'd9) begin
            return d;
        end
        return c - CH_HEX_A;
    endfunction

endpackage

FILE: design/nss_ram.sv
// nss_ram: generic single write port, single read port ram with registered read
// no package dependencies
module nss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/nss_datapath.sv
// nss_datapath: sentence store, running and header xor, checksum compare,
// config registers and the output register; uses nss_pkg and nss_ram
module nss_datapath
    import nss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast,
    output logic [3:0]  o_m_tuser
);

    logic [7:0]        r_gga_xor;
    logic [7:0]        r_rmc_xor;
    logic [FILL_W-1:0] r_fill;
    logic [7:0]        r_run_xor;
    logic [7:0]        r_hdr_xor;
    logic              r_star;
    logic              r_ovf;
    logic [7:0]        r_last;
    logic [7:0]        r_prev;
    logic [FILL_W-1:0] r_rd_idx;
    logic              r_out_valid;
    logic [7:0]        r_out_data;
    logic              r_out_last;
    logic [3:0]        r_out_user;

    logic              full;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_rdata;
    logic [7:0]        sum;
    logic [7:0]        hi_digit;
    logic [1:0]        kind;
    logic [FILL_W-1:0] rd_next;

    assign full      = (r_fill == FILL_W'(SENTENCE_BYTES));
    assign ram_we    = i_cmd.start || (i_cmd.store && !full);
    assign ram_waddr = i_cmd.start ? ADDR_W'(0) : r_fill[ADDR_W-1:0];
    assign rd_next   = r_rd_idx + FILL_W'(1);

    nss_ram #(
        .WIDTH(8),
        .DEPTH(SENTENCE_BYTES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_rx_byte),
        .i_re   (i_cmd.rd_issue),
        .i_raddr(r_rd_idx[ADDR_W-1:0]),
        .o_rdata(ram_rdata)
    );

    // transmitted checksum from the two last stored characters
    assign hi_digit = hex_digit(r_prev);
    assign sum      = {hi_digit[3:0], 4'd0} + hex_digit(r_last);

    always_comb begin
        priority if (r_hdr_xor == r_gga_xor) begin
            kind = KIND_GGA;
        end else if (r_hdr_xor == r_rmc_xor) begin
            kind = KIND_RMC;
        end else begin
            kind = KIND_UNKNOWN;
        end
    end

    assign o_sts.is_dollar = (i_rx_byte == CH_DOLLAR);
    assign o_sts.is_cr     = (i_rx_byte == CH_CR);
    assign o_sts.sum_ok    = !r_ovf && (r_fill >= FILL_W'(2)) && (sum == r_run_xor);
    assign o_sts.out_free  = !r_out_valid || i_m_tready;
    assign o_sts.play_last = (rd_next == r_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gga_xor <= 8'd86;
            r_rmc_xor <= 8'd75;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GGA_XOR: r_gga_xor <= i_cfg_data;
                CFG_RMC_XOR: r_rmc_xor <= i_cfg_data;
                default:     r_gga_xor <= r_gga_xor;
            endcase
        end
    end

    // sentence collection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_run_xor <= '0;
            r_hdr_xor <= '0;
            r_star    <= 1'b0;
            r_ovf     <= 1'b0;
        end else if (i_cmd.start) begin
            // '$' is stored but never enters the xor
            r_fill    <= FILL_W'(1);
            r_run_xor <= '0;
            r_hdr_xor <= '0;
            r_star    <= 1'b0;
            r_ovf     <= 1'b0;
            r_last    <= i_rx_byte;
        end else if (i_cmd.store) begin
            if (full) begin
                r_ovf <= 1'b1;
            end else begin
                r_fill <= r_fill + FILL_W'(1);
                r_prev <= r_last;
                r_last <= i_rx_byte;
                if (i_rx_byte == CH_STAR) begin
                    r_star <= 1'b1;
                end else if (i_rx_byte != CH_DOLLAR && !r_star) begin
                    r_run_xor <= r_run_xor ^ i_rx_byte;
                    if (r_fill < FILL_W'(HEADER_LEN)) begin
                        r_hdr_xor <= r_hdr_xor ^ i_rx_byte;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (i_cmd.play_init) begin
            r_rd_idx <= '0;
        end else if (i_cmd.load_byte) begin
            r_rd_idx <= rd_next;
        end
    end

    // output register, user bits: byte_valid, checksum_ok, sentence_kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_status || i_cmd.load_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_status) begin
            r_out_data <= '0;
            r_out_last <= 1'b1;
            r_out_user <= {KIND_UNKNOWN, 1'b0, 1'b0};
        end else if (i_cmd.load_byte) begin
            r_out_data <= ram_rdata;
            r_out_last <= (rd_next == r_fill);
            r_out_user <= {kind, 1'b1, 1'b1};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

endmodule

FILE: design/nss_ctrl.sv
// nss_ctrl: sequencer for hunting, collecting, checking and playback
// uses nss_pkg command and status types
module nss_ctrl
    import nss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_HUNT,
        S_COLLECT,
        S_CHECK,
        S_READ,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_s_tready = (r_state == S_HUNT) || (r_state == S_COLLECT);
    assign accept     = o_s_tready && i_s_tvalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT: begin
                if (accept && i_sts.is_dollar) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_COLLECT;
                end
            end
            S_COLLECT: begin
                if (accept) begin
                    if (i_sts.is_cr) begin
                        n_state = S_CHECK;
                    end else begin
                        o_cmd.store = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.sum_ok) begin
                    o_cmd.play_init = 1'b1;
                    n_state         = S_READ;
                end else if (i_sts.out_free) begin
                    o_cmd.load_status = 1'b1;
                    n_state           = S_HUNT;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_byte = 1'b1;
                    n_state         = i_sts.play_last ? S_HUNT : S_READ;
                end
            end
            default: n_state = S_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/nmea_sentence_splitter.sv
// nmea_sentence_splitter: nmea 0183 sentence framer with checksum check
// uses nss_pkg, nss_ctrl, nss_datapath (which holds nss_ram)
//
// usage: serial characters enter on the s channel, one beat per character.
// characters are dropped until '$'; from there they are stored up to the
// carriage return. on the carriage return the two last stored characters are
// compared as hex against the xor of the sentence (between '$' and '*').
// on a match the stored sentence, '$' included, leaves on the m channel one
// beat per character, typed gga, rmc or unknown by the xor of the five characters
// after '$'; on a mismatch, overflow or short sentence one invalid status
// beat leaves. tlast marks the final beat of each run.
// timing: characters are taken at one per cycle while hunting or collecting.
// after the carriage return comes a check state, from which the status beat
// is loaded once the output register is free; playback alternates read and
// load states, set by the registered read of the store. s_tready is low from
// the carriage return until the last beat is loaded in the output register.
// reset: the block hunts for '$', the output is empty, the type registers
// take their default values. a stalled receiver holds the output register
// and playback waits; stored characters are still taken while hunting or
// collecting with a beat pending.
module nmea_sentence_splitter
    import nss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // rx_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // data_byte
    output logic       o_m_tlast,    // last_of_run
    output logic [3:0] o_m_tuser,    // [0] byte_valid, [1] checksum_ok, [3:2] sentence_kind
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,  // 0 gga_header_xor, 1 rmc_header_xor
    input  logic [7:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    nss_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    nss_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_rx_byte  (i_s_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for nmea_sentence_splitter, the nmea sentence framer
// depends on nss_pkg and the design files; a local frame tracker predicts every beat
module tb_top;
    import nss_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_BYTES = 50;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       last;
        logic       ok;
        logic [1:0] kind;
    } t_sentence_beat;

    // the beat sent for a bad checksum, an overflow or a short sentence
    localparam t_sentence_beat STATUS_BEAT = '{8'h00, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN};

    typedef struct packed {
        logic [7:0] rx;
        logic       typed_status;  // carriage return that must give the status beat
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;    // rx_byte
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;    // data_byte
    logic       o_m_tlast;    // last_of_run
    logic [3:0] o_m_tuser;    // [0] byte_valid, [1] checksum_ok, [3:2] sentence_kind
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [7:0] i_cfg_data;

    nmea_sentence_splitter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // frame tracker state
    logic       trk_hunting;
    logic [7:0] trk_store [SENTENCE_BYTES];
    int         trk_fill;
    logic [7:0] trk_xor;
    logic       trk_star;
    logic [7:0] trk_hdr;
    logic       trk_ovf;
    logic [7:0] kind_gga_xor;
    logic [7:0] kind_rmc_xor;

    t_sentence_beat beats_due [$];
    t_sentence_beat fresh_beats [$];
    logic [7:0]     burst [$];

    int mismatches;
    int quiet_cycles;
    bit s_idle_en;
    bit long_hold_req;

    t_dir_row dir_rows [24] = '{
        '{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{CH_CR, 1'b0},
        '{CH_DOLLAR, 1'b0}, '{CH_CR, 1'b1},
        '{CH_DOLLAR, 1'b0}, '{"0", 1'b0}, '{"0", 1'b0}, '{CH_CR, 1'b0},
        '{CH_DOLLAR, 1'b0}, '{"A", 1'b0}, '{CH_STAR, 1'b0}, '{"4", 1'b0},
        '{"1", 1'b0}, '{CH_CR, 1'b0},
        '{CH_DOLLAR, 1'b0}, '{"A", 1'b0}, '{CH_STAR, 1'b0}, '{"4", 1'b0},
        '{"2", 1'b0}, '{CH_CR, 1'b1},
        '{CH_DOLLAR, 1'b0}, '{CH_DOLLAR, 1'b0}, '{CH_CR, 1'b1}
    };

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return (d < 8'd10) ? d : c - CH_HEX_A;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_HEX_A + 8'(v);
    endfunction

    function automatic logic [7:0] any_but_cr();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return (c == CH_CR) ? c + 8'd1 : c;
    endfunction

    task automatic open_sentence();
        trk_fill = 0;
        trk_xor  = 8'h00;
        trk_star = 1'b0;
        trk_hdr  = 8'h00;
        trk_ovf  = 1'b0;
    endtask

    task automatic keep_byte(input logic [7:0] b);
        if (trk_fill >= SENTENCE_BYTES) begin
            trk_ovf = 1'b1;
        end else begin
            trk_store[trk_fill] = b;
            if (b == CH_STAR) begin
                trk_star = 1'b1;
            end else if (b != CH_DOLLAR && !trk_star) begin
                trk_xor = trk_xor ^ b;
                if (trk_fill < HEADER_LEN) begin
                    trk_hdr = trk_hdr ^ b;
                end
            end
            trk_fill++;
        end
    endtask

    // advances the tracker by one received byte and leaves its beats in fresh_beats
    task automatic frame_rx_byte(input logic [7:0] b);
        logic [7:0]     sum;
        logic [1:0]     kind;
        logic           good;
        t_sentence_beat beat;
        fresh_beats.delete();
        if (trk_hunting) begin
            if (b == CH_DOLLAR) begin
                trk_hunting = 1'b0;
                open_sentence();
                keep_byte(b);
            end
        end else if (b != CH_CR) begin
            keep_byte(b);
        end else begin
            good = 1'b0;
            if (!trk_ovf && trk_fill >= 2) begin
                sum  = (nibble_of(trk_store[trk_fill - 2]) << 4)
                     + nibble_of(trk_store[trk_fill - 1]);
                good = (sum == trk_xor);
            end
            trk_hunting = 1'b1;
            if (!good) begin
                fresh_beats.push_back(STATUS_BEAT);
            end else begin
                if (trk_hdr == kind_gga_xor) begin
                    kind = KIND_GGA;
                end else if (trk_hdr == kind_rmc_xor) begin
                    kind = KIND_RMC;
                end else begin
                    kind = KIND_UNKNOWN;
                end
                for (int k = 0; k < trk_fill; k++) begin
                    beat = '{trk_store[k], 1'b1, k == trk_fill - 1, 1'b1, kind};
                    fresh_beats.push_back(beat);
                end
            end
            open_sentence();
        end
    endtask

    task automatic push_rx_byte(input logic [7:0] rx, input logic typed_status);
        int gap;
        gap = s_idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= rx;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        frame_rx_byte(rx);
        if (typed_status) begin
            beats_due.push_back(STATUS_BEAT);
        end else begin
            foreach (fresh_beats[k]) beats_due.push_back(fresh_beats[k]);
        end
        @(negedge i_clk);
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            burst.push_back(s[k]);
        end
    endtask

    // one random sequence: mostly checksummed sentences, the rest noise and broken ones
    task automatic build_burst(output bit ignored);
        int         shape;
        int         body_len;
        int         pick;
        logic [7:0] c;
        logic [7:0] sum;
        logic [7:0] target;
        burst.delete();
        ignored = 1'b0;
        shape = $urandom_range(0, 99);
        if (shape < 10) begin
            ignored = 1'b1;
            repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom_range(0, 255)));
        end else if (shape < 88) begin
            burst.push_back(CH_DOLLAR);
            pick = $urandom_range(0, 3);
            if (pick == 0) begin
                push_text("GPGGA");
            end else if (pick == 1) begin
                push_text("GPRMC");
            end else begin
                // four letters, the fifth chosen to land on a programmed header xor
                target = (pick == 2) ? kind_gga_xor : kind_rmc_xor;
                repeat (4) begin
                    c = 8'($urandom_range(65, 90));
                    target = target ^ c;
                    burst.push_back(c);
                end
                burst.push_back((target == CH_CR) ? "Z" : target);
            end
            body_len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 55)
                                                   : $urandom_range(0, 12);
            repeat (body_len) begin
                c = any_but_cr();
                burst.push_back((c == CH_STAR) ? "+" : c);
            end
            sum = 8'h00;
            for (int k = 1; k < burst.size(); k++) begin
                if (burst[k] != CH_DOLLAR) sum = sum ^ burst[k];
            end
            if (shape >= 80) begin
                sum = sum ^ (8'h01 << $urandom_range(0, 7));
            end
            burst.push_back(CH_STAR);
            burst.push_back(hex_char(sum[7:4]));
            burst.push_back(hex_char(sum[3:0]));
            burst.push_back(CH_CR);
        end else begin
            burst.push_back(CH_DOLLAR);
            if (shape < 93) begin
                repeat ($urandom_range(63, 70)) burst.push_back(any_but_cr());
            end else if (shape < 97) begin
                repeat ($urandom_range(0, 3)) burst.push_back(any_but_cr());
            end else begin
                repeat ($urandom_range(1, 20)) burst.push_back(8'($urandom_range(0, 255)));
            end
            burst.push_back(CH_CR);
        end
    endtask

    task automatic random_phase(input int quota);
        int sent;
        bit ignored;
        sent = 0;
        while (sent < quota) begin
            build_burst(ignored);
            s_idle_en = ($urandom_range(0, 4) != 0);
            foreach (burst[k]) push_rx_byte(burst[k], 1'b0);
            if (!ignored) sent += burst.size();
        end
        // closes any sentence a noise burst may have opened
        push_rx_byte(CH_CR, 1'b0);
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (beats_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_kind_regs(input logic [7:0] gga, input logic [7:0] rmc);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_GGA_XOR;
        i_cfg_data  <= gga;
        @(negedge i_clk);
        i_cfg_index <= CFG_RMC_XOR;
        i_cfg_data  <= rmc;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        kind_gga_xor = gga;
        kind_rmc_xor = rmc;
        @(negedge i_clk);
    endtask

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_beat();
        t_sentence_beat want;
        if (beats_due.size() == 0) begin
            $error("unexpected beat, data_byte %0h", o_m_tdata);
            mismatches++;
        end else begin
            want = beats_due.pop_front();
            report_field("data_byte", want.data, o_m_tdata);
            report_field("byte_valid", 8'(want.byte_valid), 8'(o_m_tuser[0]));
            report_field("last_of_run", 8'(want.last), 8'(o_m_tlast));
            report_field("checksum_ok", 8'(want.ok), 8'(o_m_tuser[1]));
            report_field("sentence_kind", 8'(want.kind), 8'(o_m_tuser[3:2]));
        end
    endtask

    initial begin : beat_sink
        int wait_cycles;
        int beat_no;
        bit m_idle_en;
        i_m_tready = 1'b0;
        m_idle_en  = 1'b1;
        beat_no    = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (beat_no % 32 == 0) m_idle_en = ($urandom_range(0, 3) != 0);
            wait_cycles = m_idle_en ? $urandom_range(0, 10) : 0;
            if (long_hold_req) begin
                wait_cycles   = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (wait_cycles > 0) begin
                i_m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
            check_beat();
            beat_no++;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = 8'h00;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_GGA_XOR;
        i_cfg_data    = 8'h00;
        mismatches    = 0;
        quiet_cycles  = 0;
        long_hold_req = 1'b0;
        s_idle_en     = 1'b1;
        kind_gga_xor  = 8'd86;
        kind_rmc_xor  = 8'd75;
        trk_hunting   = 1'b1;
        open_sentence();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) push_rx_byte(dir_rows[r].rx, dir_rows[r].typed_status);
        random_phase(PHASE_BYTES);

        for (int p = 0; p < 4; p++) begin
            settle();
            case (p)
                0: write_kind_regs(8'd0, 8'd255);
                1: write_kind_regs(8'd255, 8'd0);
                2: write_kind_regs(8'd86, 8'd86);  // both match: gga takes it
                default: write_kind_regs(8'($urandom_range(0, 255)),
                                         8'($urandom_range(0, 255)));
            endcase
            // receiver stalls long while the sender keeps going
            if (p == 1) long_hold_req = 1'b1;
            random_phase(PHASE_BYTES);
        end
        settle();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && beats_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/nss_pkg.sv
design/nss_ram.sv
design/nss_datapath.sv
design/nss_ctrl.sv
design/nmea_sentence_splitter.sv
bench/tb_top.sv
